### hdl/dds_pkg.sv
// Shared types, constants and functions for the decimal denomination split.
// Used by the controller, the datapath, the top level and the checker.
package dds_pkg;

   localparam int AMOUNT_WIDTH  = 64;
   localparam int DIGITS        = 20;
   localparam int BCD_WIDTH     = 4 * DIGITS;
   localparam int BITS_PER_STEP = 4;
   localparam int CONV_STEPS    = AMOUNT_WIDTH / BITS_PER_STEP;
   localparam int STEP_WIDTH    = $clog2(CONV_STEPS);
   localparam int PLACE_WIDTH   = $clog2(DIGITS);

   typedef logic [AMOUNT_WIDTH-1:0] amount_type;
   typedef logic [BCD_WIDTH-1:0]    bcd_type;
   typedef logic [PLACE_WIDTH-1:0]  place_type;
   typedef logic [STEP_WIDTH-1:0]   step_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic convert;
      logic advance;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic bcd_zero;
      logic digit_zero;
      logic out_free;
   } status_type;

   function automatic amount_type pow10(input place_type place);
      amount_type p;
      case (place)
         5'd0:    p = 64'd1;
         5'd1:    p = 64'd10;
         5'd2:    p = 64'd100;
         5'd3:    p = 64'd1000;
         5'd4:    p = 64'd10000;
         5'd5:    p = 64'd100000;
         5'd6:    p = 64'd1000000;
         5'd7:    p = 64'd10000000;
         5'd8:    p = 64'd100000000;
         5'd9:    p = 64'd1000000000;
         5'd10:   p = 64'd10000000000;
         5'd11:   p = 64'd100000000000;
         5'd12:   p = 64'd1000000000000;
         5'd13:   p = 64'd10000000000000;
         5'd14:   p = 64'd100000000000000;
         5'd15:   p = 64'd1000000000000000;
         5'd16:   p = 64'd10000000000000000;
         5'd17:   p = 64'd100000000000000000;
         5'd18:   p = 64'd1000000000000000000;
         5'd19:   p = 64'd10000000000000000000;
         default: p = 64'd0;
      endcase
      return p;
   endfunction

   // one shift-and-add-3 step of binary to BCD conversion
   function automatic bcd_type dabble_bit(input bcd_type b, input logic bit_in);
      bcd_type t;
      t = b;
      for (int i = 0; i < DIGITS; i++) begin
         if (t[4*i +: 4] >= 4'd5) begin
            t[4*i +: 4] = t[4*i +: 4] + 4'd3;
         end
      end
      return {t[BCD_WIDTH-2:0], bit_in};
   endfunction

endpackage

### hdl/dds_controller.sv
// Sequencer for the decimal denomination split: idle, convert, emit.
// Depends on dds_pkg; drives datapath commands from its status.
module dds_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  dds_pkg::status_type status,
   output dds_pkg::cmd_type    cmd
);
   import dds_pkg::*;

   state_type state_ff, state_in;
   step_type  step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (req_valid) begin
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            step_in = step_ff + 1'b1;
            if (step_ff == step_type'(CONV_STEPS - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.bcd_zero) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_CONVERT: begin
            cmd.convert = 1'b1;
         end
         ST_EMIT: begin
            if (!status.bcd_zero) begin
               if (status.digit_zero) begin
                  cmd.advance = 1'b1;
               end else if (status.out_free) begin
                  cmd.emit    = 1'b1;
                  cmd.advance = 1'b1;
               end
            end
         end
         default: cmd = '0;
      endcase
   end

endmodule

### hdl/dds_datapath.sv
// Datapath: binary to BCD shifter, digit walker and result word register.
// Depends on dds_pkg; steered by dds_controller.
module dds_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  dds_pkg::cmd_type     cmd,
   output dds_pkg::status_type  status,
   input  dds_pkg::amount_type  req_amount,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output dds_pkg::amount_type  rsp_denomination,
   output logic                 rsp_last
);
   import dds_pkg::*;

   amount_type bin_ff, bin_in;
   bcd_type    bcd_ff, bcd_in;
   place_type  place_ff, place_in;
   amount_type denom_ff, denom_in;
   logic       last_ff, last_in;
   logic       valid_ff, valid_in;
   bcd_type    conv;
   logic [3:0] digit;

   assign digit = bcd_ff[3:0];

   always_comb begin
      conv = bcd_ff;
      for (int j = 0; j < BITS_PER_STEP; j++) begin
         conv = dabble_bit(conv, bin_ff[AMOUNT_WIDTH-1-j]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      bin_ff   <= bin_in;
      bcd_ff   <= bcd_in;
      place_ff <= place_in;
      denom_ff <= denom_in;
      last_ff  <= last_in;
   end

   always_comb begin
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      place_in = place_ff;
      denom_in = denom_ff;
      last_in  = last_ff;
      valid_in = valid_ff && !rsp_ready;
      if (cmd.load) begin
         bin_in   = req_amount;
         bcd_in   = '0;
         place_in = '0;
      end
      if (cmd.convert) begin
         bin_in = {bin_ff[AMOUNT_WIDTH-BITS_PER_STEP-1:0], {BITS_PER_STEP{1'b0}}};
         bcd_in = conv;
      end
      if (cmd.emit) begin
         denom_in = amount_type'(pow10(place_ff) * digit);
         last_in  = (bcd_ff[BCD_WIDTH-1:4] == '0);
         valid_in = 1'b1;
      end
      if (cmd.advance) begin
         bcd_in   = {4'd0, bcd_ff[BCD_WIDTH-1:4]};
         place_in = place_ff + 1'b1;
      end
   end

   assign status.bcd_zero   = (bcd_ff == '0);
   assign status.digit_zero = (digit == 4'd0);
   assign status.out_free   = !valid_ff || rsp_ready;

   assign rsp_valid        = valid_ff;
   assign rsp_denomination = denom_ff;
   assign rsp_last         = last_ff;

endmodule

### hdl/decimal_denomination_split.sv
// Top level of the decimal denomination split.
// Depends on dds_pkg, dds_controller and dds_datapath.
//
// Usage:
//   req_ channel carries one 64-bit unsigned amount per word (req_amount).
//   rsp_ channel returns one word per nonzero decimal digit, least
//   significant place first: rsp_denomination = digit * 10^place, and
//   rsp_last marks the word from the most significant nonzero digit.
//   An amount of zero returns no words.
//   Timing: req_ready is high only while the block is idle. An accepted
//   amount first runs through the binary to BCD shifter (4 bits per
//   cycle), then the digit walker visits one decimal place per cycle up to
//   the top nonzero digit, pausing while a nonzero digit waits for the
//   output register, before the block is idle again.
//   The result word sits in an output register; while the receiver holds
//   rsp_ready low the walker pauses on the next nonzero digit.
//   Reset (synchronous, active high) returns to idle and drops any pending
//   result word.
module decimal_denomination_split (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  dds_pkg::amount_type req_amount,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output dds_pkg::amount_type rsp_denomination,
   output logic                rsp_last
);
   import dds_pkg::*;

   cmd_type    cmd;
   status_type status;

   dds_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dds_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_amount       (req_amount),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_denomination (rsp_denomination),
      .rsp_last         (rsp_last)
   );

endmodule

### hdl/dds_checker.sv
// Port-level checker for decimal_denomination_split, bound to the top level.
// Depends on dds_pkg.
module dds_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input dds_pkg::amount_type req_amount,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input dds_pkg::amount_type rsp_denomination,
   input logic                rsp_last
);
   import dds_pkg::*;

   // hold a stalled result word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_denomination)
                                  && $stable(rsp_last))
      else $error("stalled result word changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_denomination != '0)
      else $error("zero denomination emitted");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted a word while converting");

   // hold a waiting request word
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_amount))
      else $error("waiting request word changed");

endmodule

bind decimal_denomination_split dds_checker u_chk (.*);

### tb/dds_denomination_checker.sv
// Checker for the decimal denomination split: watches both channels, predicts
// the denomination words of each accepted amount and compares them in order.
// Depends on dds_pkg.
`timescale 1ns / 100ps

module dds_denomination_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  dds_pkg::amount_type req_amount,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  dds_pkg::amount_type rsp_denomination,
   input  logic                rsp_last,
   output int                  failures,
   output int                  pending,
   output int                  amounts_seen,
   output int                  words_seen
);
   import dds_pkg::*;

   localparam amount_type DECIMAL_BASE = 64'd10;

   typedef struct {
      amount_type denomination;
      logic       last;
   } denom_word_type;

   denom_word_type expected_denoms[$];

   function automatic void split_amount(input amount_type amount);
      amount_type     rest;
      amount_type     scale;
      amount_type     digit;
      denom_word_type w;
      rest  = amount;
      scale = 64'd1;
      while (rest != 0) begin
         digit = rest % DECIMAL_BASE;
         rest  = rest / DECIMAL_BASE;
         if (digit != 0) begin
            w.denomination = digit * scale;
            w.last         = (rest == 0);
            expected_denoms.insert(expected_denoms.size(), w);
         end
         if (rest != 0) begin
            scale = scale * DECIMAL_BASE;
         end
      end
   endfunction

   initial begin
      failures     = 0;
      pending      = 0;
      amounts_seen = 0;
      words_seen   = 0;
   end

   always @(posedge clock) begin
      denom_word_type w;
      if (reset) begin
         expected_denoms.delete();
      end else begin
         if (req_valid && req_ready) begin
            split_amount(req_amount);
            amounts_seen++;
         end
         if (rsp_valid && rsp_ready) begin
            words_seen++;
            if (expected_denoms.size() == 0) begin
               $error("unexpected word: denomination %0d last %0b",
                      rsp_denomination, rsp_last);
               failures++;
            end else begin
               w = expected_denoms.pop_front();
               if (rsp_denomination !== w.denomination) begin
                  $error("denomination: expected %0d, actual %0d",
                         w.denomination, rsp_denomination);
                  failures++;
               end
               if (rsp_last !== w.last) begin
                  $error("last: expected %0b, actual %0b", w.last, rsp_last);
                  failures++;
               end
            end
         end
      end
      pending <= expected_denoms.size();
   end

endmodule

### tb/tb_decimal_denomination_split.sv
// Testbench top for the decimal denomination split: drives amounts and the
// result back-pressure, and gives the verdict.
// Depends on dds_pkg, decimal_denomination_split and dds_denomination_checker.
`timescale 1ns / 100ps

module tb_decimal_denomination_split;
   import dds_pkg::*;

   localparam int         RANDOM_PER_PHASE = 52;
   localparam int         HOLD_CYCLES      = 300;
   localparam int         STALL_LIMIT      = 4000;
   localparam int         DRAIN_CYCLES     = 60;
   localparam int         DIRECTED_COUNT   = 16;
   localparam amount_type TOP_PLACE        = 64'd10000000000000000000;

   localparam amount_type DIRECTED_AMOUNTS [DIRECTED_COUNT] = '{
      64'd0,
      64'd1,
      64'd9,
      64'd10,
      64'd90,
      64'd101,
      64'd1000000000,
      64'd18446744073709551615,
      64'd10000000000000000000,
      64'd9999999999999999999,
      64'd10000000000000000001,
      64'd18000000000000000009,
      64'd12345678901234567890,
      64'd0,
      64'd9000000000000000000,
      64'd5000000000000000000
   };

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   amount_type req_amount;
   logic       rsp_valid;
   logic       rsp_ready;
   amount_type rsp_denomination;
   logic       rsp_last;

   int failures;
   int pending;
   int amounts_seen;
   int words_seen;
   int send_idle_pct;
   int recv_idle_pct;
   int stall_cycles;
   bit hold_request;

   decimal_denomination_split dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_amount       (req_amount),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_denomination (rsp_denomination),
      .rsp_last         (rsp_last)
   );

   dds_denomination_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_amount       (req_amount),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_denomination (rsp_denomination),
      .rsp_last         (rsp_last),
      .failures         (failures),
      .pending          (pending),
      .amounts_seen     (amounts_seen),
      .words_seen       (words_seen)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // offer one amount, idling first at random, and hold it until accepted
   task automatic offer_amount(input amount_type amount);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_amount <= amount;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic amount_type random_amount();
      amount_type a;
      amount_type scale;
      int         width;
      int         places;
      int         kind;
      kind = $urandom_range(3);
      case (kind)
         0: begin
            a = {$urandom, $urandom};
         end
         1: begin
            width = $urandom_range(64);
            a     = {$urandom, $urandom};
            if (width < 64) begin
               a = a & ((64'd1 << width) - 64'd1);
            end
         end
         default: begin
            // sparse decimal digits, some with the top place set
            a      = '0;
            scale  = 64'd1;
            places = (kind == 3) ? $urandom_range(18) : $urandom_range(19, 1);
            for (int k = 0; k < places; k++) begin
               if ($urandom_range(99) < 40) begin
                  a = a + amount_type'($urandom_range(9, 1)) * scale;
               end
               scale = scale * 64'd10;
            end
            if (kind == 3) begin
               a = a + TOP_PLACE;
            end
         end
      endcase
      return a;
   endfunction

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            for (int i = 0; i < HOLD_CYCLES; i++) begin
               rsp_ready <= 1'b0;
               @(negedge clock);
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
      end
      $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_amount    = '0;
      send_idle_pct = 21;
      recv_idle_pct = 57;
      hold_request  = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         offer_amount(DIRECTED_AMOUNTS[i]);
      end
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
         offer_amount(random_amount());
      end

      send_idle_pct = 57;
      recv_idle_pct = 21;
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
         offer_amount(random_amount());
      end

      // no idling; hold the receiver off so the block backs up into its input
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request  = 1'b1;
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
         offer_amount(random_amount());
      end
      req_valid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d amounts giving %0d denomination words,", amounts_seen,
               words_seen);
      $display("under input stalls, output stalls and a %0d-cycle output hold",
               HOLD_CYCLES);
      if (failures == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

### decimal_denomination_split.f
hdl/dds_pkg.sv
hdl/dds_controller.sv
hdl/dds_datapath.sv
hdl/decimal_denomination_split.sv
hdl/dds_checker.sv
tb/dds_denomination_checker.sv
tb/tb_decimal_denomination_split.sv
